// File: rtl/assert_macros.svh
// Assertion macros used by the deframer state machine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SEFXR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("sefxr assertion failed");

// Check a property on every clock edge, reset included.
`define SEFXR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("sefxr assertion failed");

`endif

// File: rtl/sefxr_pkg.sv
// Types and constants shared by the byte-stream deframer.
package sefxr_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int RES_W      = BYTE_W + POS_W + STATUS_W;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

    // Smallest size byte accepted (it counts itself)
    localparam logic [BYTE_W-1:0] MIN_SIZE = 8'd2;

    // Reset value of the largest accepted size
    localparam logic [BYTE_W-1:0] LARGEST_SIZE_RST = 8'd255;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_START_FIRST  = 3'd0;
    localparam logic [2:0] REG_START_SECOND = 3'd1;
    localparam logic [2:0] REG_END_FIRST    = 3'd2;
    localparam logic [2:0] REG_END_SECOND   = 3'd3;
    localparam logic [2:0] REG_LARGEST_SIZE = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SOF1 = 3'd1,
        PH_SOF2 = 3'd2,
        PH_BODY = 3'd3,
        PH_DONE = 3'd4,
        PH_EOF1 = 3'd5,
        PH_EOF2 = 3'd6
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_DROP   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_DONE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] end_first;
        logic [BYTE_W-1:0] end_second;
        logic [BYTE_W-1:0] largest_size;
    } t_cfg;

    // Packed so that byte_out lands in the lowest bits
    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  frame_pos;
        logic [BYTE_W-1:0] byte_out;
    } t_result;

endpackage

// File: rtl/sefxr_fsm.sv
// Frame hunting state machine with running XOR checksum.
`include "assert_macros.svh"

module sefxr_fsm
    import sefxr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_left, n_left;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic w_ok;
    logic w_done;

    // Classify the byte against the current phase and form the result
    always_comb begin
        w_ok   = 1'b0;
        w_done = 1'b0;
        case (r_phase)
            PH_IDLE: w_ok = (i_byte == i_cfg.start_first);
            PH_SOF1: w_ok = (i_byte == i_cfg.start_second);
            PH_SOF2: w_ok = (i_byte >= MIN_SIZE) && (i_byte <= i_cfg.largest_size);
            PH_BODY: w_ok = 1'b1;
            PH_DONE: w_ok = (i_byte == i_cfg.end_first);
            PH_EOF1: w_ok = (i_byte == i_cfg.end_second);
            PH_EOF2: begin
                w_ok   = (i_byte == r_xor);
                w_done = w_ok;
            end
            default: w_ok = 1'b0;
        endcase

        o_result.byte_out = i_byte;
        if (!w_ok) begin
            o_result.frame_pos = '0;
            o_result.status    = ST_DROP;
        end else begin
            o_result.frame_pos = r_pos;
            o_result.status    = w_done ? ST_DONE : ST_ACCEPT;
        end
    end

    // Next phase, counters and checksum
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_xor   = r_xor;
        n_pos   = r_pos;
        if (!w_ok) begin
            // Drop the byte and return to hunting; keep the byte count
            n_phase = PH_IDLE;
            n_xor   = '0;
            n_pos   = '0;
        end else if (w_done) begin
            n_phase = PH_IDLE;
            n_left  = '0;
            n_xor   = '0;
            n_pos   = '0;
        end else begin
            n_xor = r_xor ^ i_byte;
            n_pos = r_pos + POS_W'(1);
            case (r_phase)
                PH_IDLE: n_phase = PH_SOF1;
                PH_SOF1: n_phase = PH_SOF2;
                PH_SOF2: begin
                    n_phase = PH_BODY;
                    n_left  = i_byte - BYTE_W'(1);
                end
                PH_BODY: begin
                    n_phase = (r_left == BYTE_W'(1)) ? PH_DONE : PH_BODY;
                    n_left  = r_left - BYTE_W'(1);
                end
                PH_DONE: n_phase = PH_EOF1;
                PH_EOF1: n_phase = PH_EOF2;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Advance the state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
            r_xor   <= '0;
            r_pos   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_xor   <= n_xor;
            r_pos   <= n_pos;
        end
    end

    `SEFXR_ASSERT(a_done_clears, i_clk, i_rst_n,
        (i_adv && o_result.status == ST_DONE) |=>
        (r_phase == PH_IDLE && r_xor == '0 && r_pos == '0 && r_left == '0))
    `SEFXR_ASSERT(a_drop_rehunts, i_clk, i_rst_n,
        (i_adv && o_result.status == ST_DROP) |=> (r_phase == PH_IDLE && r_pos == '0))
    `SEFXR_ASSERT(a_accept_steps_pos, i_clk, i_rst_n,
        (i_adv && o_result.status == ST_ACCEPT) |=> (r_pos == $past(r_pos) + POS_W'(1)))
    `SEFXR_ASSERT(a_hold_on_stall, i_clk, i_rst_n,
        !i_adv |=> ($stable(r_phase) && $stable(r_pos) && $stable(r_xor)))

endmodule

// File: rtl/sof_eof_xor_frame_receiver.sv
// Top level of the byte-stream deframer: register port, input and result stages.
//
// Takes one received byte per request and hunts for a frame of two start
// bytes, a size byte, size-1 payload bytes, two end bytes and an XOR checksum
// of all earlier frame bytes. Every byte gives exactly one result carrying the
// echoed byte, its frame position and a status (dropped, accepted, frame
// complete). Throughput is one byte per clock cycle while the result side drains;
// a byte passes the input register, the state machine and the result register.
// A stall on the result side holds the pipeline and drops s_axis_tready once
// both stages are full. The user must write configuration registers over the
// APB port only while the stream is idle; the block itself does not enforce it.
module sof_eof_xor_frame_receiver
    import sefxr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Byte stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
    // Result stream out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [7:0] byte_out, [16:8] frame_pos,
                                                  // [18:17] status, [23:19] zero
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic       w_adv;
    logic       w_wr;
    logic [2:0] w_idx;
    t_result    w_result;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[CFG_ADDR_W-1:2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_first  <= '0;
            r_cfg.start_second <= '0;
            r_cfg.end_first    <= '0;
            r_cfg.end_second   <= '0;
            r_cfg.largest_size <= LARGEST_SIZE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_START_FIRST:  r_cfg.start_first  <= pwdata[BYTE_W-1:0];
                REG_START_SECOND: r_cfg.start_second <= pwdata[BYTE_W-1:0];
                REG_END_FIRST:    r_cfg.end_first    <= pwdata[BYTE_W-1:0];
                REG_END_SECOND:   r_cfg.end_second   <= pwdata[BYTE_W-1:0];
                REG_LARGEST_SIZE: r_cfg.largest_size <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (w_idx)
            REG_START_FIRST:  prdata = CFG_DATA_W'(r_cfg.start_first);
            REG_START_SECOND: prdata = CFG_DATA_W'(r_cfg.start_second);
            REG_END_FIRST:    prdata = CFG_DATA_W'(r_cfg.end_first);
            REG_END_SECOND:   prdata = CFG_DATA_W'(r_cfg.end_second);
            REG_LARGEST_SIZE: prdata = CFG_DATA_W'(r_cfg.largest_size);
            default:          prdata = '0;
        endcase
    end

    // Advance when a byte waits and the result register is free or drains
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sefxr_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out);

endmodule

// File: test/tb_sof_eof_xor_frame_receiver.sv
// Self-checking stream testbench for the SOF/EOF deframer with XOR checksum.
`timescale 1ns / 1ps

module tb_sof_eof_xor_frame_receiver
    import sefxr_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int REG_SLOTS    = 1 << (CFG_ADDR_W - 2);
    localparam int BODY_CAP     = 12;

    // Which byte of a frame to corrupt
    localparam int NO_BREAK       = -1;
    localparam int BREAK_CHECKSUM = -2;
    localparam int BREAK_ANY      = -3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;    // [7:0] rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;          // [7:0] byte_out, [16:8] frame_pos,
                                                  // [18:17] status, [23:19] zero
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sof_eof_xor_frame_receiver DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Stream bookkeeping
    logic [BYTE_W-1:0] pending_bytes [$];
    t_result           due_results [$];
    int                bytes_queued  = 0;
    int                results_seen  = 0;
    int                err_count     = 0;
    int                cycle_count   = 0;
    int                src_idle_pct  = 0;
    int                snk_stall_pct = 0;

    // Predicted receiver state and register copy
    t_cfg              frame_cfg = '{start_first: 8'h00, start_second: 8'h00,
                                     end_first: 8'h00, end_second: 8'h00,
                                     largest_size: LARGEST_SIZE_RST};
    t_phase            hunt_phase = PH_IDLE;
    logic [BYTE_W-1:0] body_left  = '0;
    logic [BYTE_W-1:0] check_xor  = '0;
    logic [POS_W-1:0]  next_pos   = '0;

    t_result           want;
    t_result           got;

    // Advance the frame hunter by one byte and return its result
    function automatic t_result deframe_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        logic    ok;
        logic    done;
        ok   = 1'b1;
        done = 1'b0;
        case (hunt_phase)
            PH_IDLE: begin
                if (b == frame_cfg.start_first) hunt_phase = PH_SOF1; else ok = 1'b0;
            end
            PH_SOF1: begin
                if (b == frame_cfg.start_second) hunt_phase = PH_SOF2; else ok = 1'b0;
            end
            PH_SOF2: begin
                if (b >= MIN_SIZE && b <= frame_cfg.largest_size) begin
                    hunt_phase = PH_BODY;
                    body_left  = b - 8'd1;
                end else begin
                    ok = 1'b0;
                end
            end
            PH_BODY: begin
                hunt_phase = (body_left == 8'd1) ? PH_DONE : PH_BODY;
                body_left  = body_left - 8'd1;
            end
            PH_DONE: begin
                if (b == frame_cfg.end_first) hunt_phase = PH_EOF1; else ok = 1'b0;
            end
            PH_EOF1: begin
                if (b == frame_cfg.end_second) hunt_phase = PH_EOF2; else ok = 1'b0;
            end
            PH_EOF2: begin
                if (b == check_xor) done = 1'b1; else ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase

        r.byte_out = b;
        if (ok) begin
            r.frame_pos = next_pos;
            r.status    = done ? ST_DONE : ST_ACCEPT;
            next_pos    = next_pos + 1'b1;
            check_xor   = check_xor ^ b;
            if (done) begin
                hunt_phase = PH_IDLE;
                body_left  = '0;
                check_xor  = '0;
                next_pos   = '0;
            end
        end else begin
            r.frame_pos = '0;
            r.status    = ST_DROP;
            next_pos    = '0;
            check_xor   = '0;
            hunt_phase  = PH_IDLE;
        end
        return r;
    endfunction

    // Offer queued bytes; predict each byte at the edge that takes it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_results.push_back(deframe_byte(s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tdata  <= pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each result request against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen = results_seen + 1;
                got = m_axis_tdata[RES_W-1:0];
                if (m_axis_tdata[M_TDATA_W-1:RES_W] != '0) begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[M_TDATA_W-1:RES_W]);
                    err_count++;
                end
                if (due_results.size() == 0) begin
                    $error("result with nothing due: byte_out %0h", got.byte_out);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.byte_out != want.byte_out) begin
                        $error("byte_out: expected %0h, got %0h", want.byte_out, got.byte_out);
                        err_count++;
                    end
                    if (got.frame_pos != want.frame_pos) begin
                        $error("frame_pos: expected %0d, got %0d",
                               want.frame_pos, got.frame_pos);
                        err_count++;
                    end
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sof_eof_xor_frame_receiver failed");
            $finish;
        end
    end

    // Write one register over APB and mirror it in the predictor
    task automatic reg_write(input logic [2:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 2;
        pwdata  <= {$urandom} & 32'hFFFF_FF00 | CFG_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_FIRST:  frame_cfg.start_first  = val;
            REG_START_SECOND: frame_cfg.start_second = val;
            REG_END_FIRST:    frame_cfg.end_first    = val;
            REG_END_SECOND:   frame_cfg.end_second   = val;
            REG_LARGEST_SIZE: frame_cfg.largest_size = val;
            default: ;
        endcase
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Queue a frame built from the current markers, optionally with one bad byte
    task automatic queue_frame(input logic [BYTE_W-1:0] size, input int body_len,
                               input int break_at);
        logic [BYTE_W-1:0] frame_bytes [$];
        logic [BYTE_W-1:0] sum;
        frame_bytes.push_back(frame_cfg.start_first);
        frame_bytes.push_back(frame_cfg.start_second);
        frame_bytes.push_back(size);
        repeat (body_len) frame_bytes.push_back(BYTE_W'($urandom));
        frame_bytes.push_back(frame_cfg.end_first);
        frame_bytes.push_back(frame_cfg.end_second);
        sum = '0;
        foreach (frame_bytes[i]) sum ^= frame_bytes[i];
        frame_bytes.push_back(sum);
        if (break_at == BREAK_CHECKSUM) break_at = frame_bytes.size() - 1;
        if (break_at == BREAK_ANY) break_at = $urandom_range(frame_bytes.size() - 1);
        if (break_at >= 0) frame_bytes[break_at] ^= BYTE_W'($urandom_range(255, 1));
        foreach (frame_bytes[i]) put_byte(frame_bytes[i]);
    endtask

    // Mostly good frames, some broken or oversize ones, some line noise
    task automatic queue_traffic(input int n_bytes, input bit max_first);
        int                target;
        int                pick;
        int                top;
        int                body_len;
        logic [BYTE_W-1:0] size;
        target = bytes_queued + n_bytes;
        top    = (frame_cfg.largest_size < BODY_CAP) ? frame_cfg.largest_size : BODY_CAP;
        while (bytes_queued < target) begin
            pick = $urandom_range(99);
            if (frame_cfg.largest_size < MIN_SIZE) begin
                size = BYTE_W'($urandom);
            end else if (max_first || $urandom_range(39) == 0) begin
                size = frame_cfg.largest_size;
            end else begin
                size = BYTE_W'($urandom_range(top, MIN_SIZE));
            end
            max_first = 1'b0;
            if (pick < 75 && pick >= 65 && frame_cfg.largest_size != 8'hFF) begin
                size = BYTE_W'($urandom_range(255, frame_cfg.largest_size + 1));
            end
            body_len = (size < MIN_SIZE || size > frame_cfg.largest_size) ?
                       $urandom_range(4) : size - 1;
            if (pick < 75) begin
                queue_frame(size, body_len, NO_BREAK);
            end else if (pick < 88) begin
                queue_frame(size, body_len, BREAK_ANY);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    put_byte(($urandom_range(3) == 0) ? frame_cfg.start_first
                                                      : BYTE_W'($urandom));
                end
            end
        end
    endtask

    // Load new markers and size limit, sometimes poking an unmapped slot
    task automatic set_link(input logic [BYTE_W-1:0] largest);
        reg_write(REG_START_FIRST, pick_byte());
        reg_write(REG_START_SECOND, pick_byte());
        reg_write(REG_END_FIRST, pick_byte());
        reg_write(REG_END_SECOND, pick_byte());
        reg_write(REG_LARGEST_SIZE, largest);
        if ($urandom_range(1) == 1) begin
            reg_write(3'($urandom_range(REG_SLOTS - 1, REG_LARGEST_SIZE + 1)),
                      BYTE_W'($urandom));
        end
    endtask

    // Hold until every queued byte has its result, then let the pipe settle
    task automatic wait_drained();
        while (results_seen < bytes_queued) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                mode;
        int                k;
        logic [BYTE_W-1:0] top;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct  = 31;
        snk_stall_pct = 70;

        // Reset markers: smallest frame, sizes zero and one, a stray 0xFF,
        // and a frame with a bad checksum
        queue_frame(MIN_SIZE, 1, NO_BREAK);
        put_byte(frame_cfg.start_first);
        put_byte(frame_cfg.start_second);
        put_byte(8'd1);
        put_byte(frame_cfg.start_first);
        put_byte(frame_cfg.start_second);
        put_byte(8'd0);
        put_byte(8'hFF);
        queue_frame(MIN_SIZE, 1, BREAK_CHECKSUM);
        wait_drained();

        // Distinct markers: a dropped byte is not taken as a new start,
        // an oversize frame, and a frame at exactly the size limit
        reg_write(REG_START_FIRST, 8'h55);
        reg_write(REG_START_SECOND, 8'hAA);
        reg_write(REG_END_FIRST, 8'h0D);
        reg_write(REG_END_SECOND, 8'h0A);
        reg_write(REG_LARGEST_SIZE, MIN_SIZE);
        reg_write(3'(REG_LARGEST_SIZE + 1), 8'h00);
        put_byte(8'h55);
        put_byte(8'h55);
        put_byte(8'hAA);
        put_byte(8'h55);
        put_byte(8'hAA);
        put_byte(MIN_SIZE + 8'd1);
        queue_frame(MIN_SIZE, 1, NO_BREAK);
        wait_drained();

        // Random traffic over several link settings and three idle profiles
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    src_idle_pct  = 31;
                    snk_stall_pct = 70;
                end
                1: begin
                    src_idle_pct  = 70;
                    snk_stall_pct = 31;
                end
                default: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
            endcase
            for (k = 0; k < 4; k++) begin
                case (k)
                    0:       top = 8'hFF;
                    1:       top = MIN_SIZE;
                    2:       top = BYTE_W'($urandom_range(1));
                    default: top = BYTE_W'($urandom_range(40, 3));
                endcase
                set_link(top);
                queue_traffic(110, mode == 0 && k == 0);
                wait_drained();
            end
        end

        if (err_count == 0) begin
            $display("tb_sof_eof_xor_frame_receiver passed");
        end else begin
            $display("tb_sof_eof_xor_frame_receiver failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sefxr_pkg.sv
rtl/sefxr_fsm.sv
rtl/sof_eof_xor_frame_receiver.sv
test/tb_sof_eof_xor_frame_receiver.sv
